// ===== sv/gbns_pkg.sv =====
// Shared types and codes for the go-back-n sender window.
`default_nettype none
package gbns_pkg;

   // Field widths fixed by the interface
   localparam int ID_W      = 32;
   localparam int OP_W      = 2;
   localparam int ACK_W     = 3;
   localparam int KIND_W    = 3;
   localparam int SMALL_W   = 3;
   localparam int TICK_W    = 8;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 2;

   // Input operation codes
   localparam logic [OP_W-1:0] OP_SEND = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   // Result kind codes
   localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REFUSED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd5;

   // Register map (word index)
   localparam logic [CSR_ADDR_W-1:0] REG_TIMEOUT   = 2'd0;
   localparam logic [TICK_W-1:0]     TIMEOUT_RESET = 8'd3;

   typedef enum logic [1:0] {
      CMD_SEND,
      CMD_ACK,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [ID_W-1:0]    packet_id;
      logic [ACK_W-1:0]   ack_seq;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESEND
   } state_type;

endpackage
`default_nettype wire

// ===== sv/go_back_n_sender_window_unit.sv =====
// Top level of the go-back-n sender window: front end, back end and register port.
// Usage:
//  - req_* channel (valid/ready): one transfer per command. operation selects
//    send (packet_id), acknowledgement (ack_seq) or timer tick; the unused
//    opcode is taken and produces nothing.
//  - rsp_* channel (valid/ready): one or more result transfers per command;
//    rsp_last marks the final one. A timeout resends every outstanding
//    packet oldest first, one transfer per cycle while rsp_ready is high.
//  - csr_* port (APB): word 0 holds timeout_ticks (8 bits, reset 3).
// Timing:
//  - A 2-entry command queue sits between front and back, so requests are
//    taken while the back end works or while a result waits on rsp_ready.
//  - Send and tick: the command passes the queue, then the result register;
//    one command per cycle sustained while rsp_ready is high.
//  - Acknowledgement: no search on an empty window, else entries are checked
//    oldest first until one matches; a resend burst: one transfer per packet.
//  - If rsp_ready is low while a result waits, the result register holds and
//    the back end stalls; the queue fills, then req_ready drops.
// Reset (synchronous): window empty, counters zero, timeout_ticks = 3.
`default_nettype none
module go_back_n_sender_window_unit #(
   parameter int WINDOW = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [gbns_pkg::OP_W-1:0]            req_operation,
   input  wire logic [gbns_pkg::ID_W-1:0]            req_packet_id,
   input  wire logic [gbns_pkg::ACK_W-1:0]           req_ack_seq,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [gbns_pkg::KIND_W-1:0]               rsp_kind,
   output logic [gbns_pkg::ID_W-1:0]                 rsp_out_packet_id,
   output logic [gbns_pkg::SMALL_W-1:0]              rsp_out_seq,
   output logic [gbns_pkg::SMALL_W-1:0]              rsp_freed_count,
   output logic [gbns_pkg::SMALL_W-1:0]              rsp_outstanding,
   output logic                                      rsp_last,
   // register port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [gbns_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [gbns_pkg::CSR_W-1:0]           csr_pwdata,
   output logic [gbns_pkg::CSR_W-1:0]                csr_prdata,
   output logic                                      csr_pready
);

   logic                          cmd_valid;
   gbns_pkg::cmd_type             cmd;
   logic                          cmd_pop;

   logic [gbns_pkg::TICK_W-1:0]   timeout_ff, timeout_in;
   logic                          csr_hit;
   logic                          csr_wr;

   // --- register port -------------------------------------------------
   // Single word; both address bits are shifted out, so every address decodes to it.
   assign csr_hit    = (gbns_pkg::CSR_ADDR_W'(csr_paddr >> 2) == gbns_pkg::REG_TIMEOUT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? gbns_pkg::CSR_W'(timeout_ff) : '0;
   assign timeout_in = (csr_wr && csr_hit) ? csr_pwdata[gbns_pkg::TICK_W-1:0] : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= gbns_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // --- front end: take requests, classify, queue ---------------------
   gbns_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_packet_id (req_packet_id),
      .req_ack_seq   (req_ack_seq),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // --- back end: window ring, ack search, retransmit -----------------
   gbns_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop),
      .timeout_ticks     (timeout_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_packet_id (rsp_out_packet_id),
      .rsp_out_seq       (rsp_out_seq),
      .rsp_freed_count   (rsp_freed_count),
      .rsp_outstanding   (rsp_outstanding),
      .rsp_last          (rsp_last)
   );

   // --- assertions ----------------------------------------------------
   // a resend burst continues on the very next cycle once a transfer completes
   a_resend_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_kind == gbns_pkg::KIND_RESEND && !rsp_last)
      |=> (rsp_valid && rsp_kind == gbns_pkg::KIND_RESEND))
      else $error("resend burst broken");

   // only acknowledgements free entries
   a_freed_only_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != gbns_pkg::KIND_ACK) |-> (rsp_freed_count == '0))
      else $error("freed count on non-ack result");

   // a refused send means the window is full
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == gbns_pkg::KIND_REFUSED)
      |-> (rsp_outstanding == gbns_pkg::SMALL_W'(WINDOW)))
      else $error("send refused with room in window");

   // a single-result command always carries last
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != gbns_pkg::KIND_RESEND) |-> rsp_last)
      else $error("last missing on single result");

endmodule
`default_nettype wire

// ===== sv/gbns_front.sv =====
// Front end: accepts request transfers, classifies them and queues commands.
`default_nettype none
module gbns_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [gbns_pkg::OP_W-1:0]     req_operation,
   input  wire logic [gbns_pkg::ID_W-1:0]     req_packet_id,
   input  wire logic [gbns_pkg::ACK_W-1:0]    req_ack_seq,
   output logic                               cmd_valid,
   output gbns_pkg::cmd_type                  cmd,
   input  wire logic                          cmd_pop
);

   localparam int DEPTH = 2;

   gbns_pkg::cmd_type q_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;
   gbns_pkg::cmd_type new_cmd;

   assign req_ready = (fill_ff != 2'(DEPTH));
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // classify; unused opcode is taken and dropped
   always_comb begin
      new_cmd.packet_id = req_packet_id;
      new_cmd.ack_seq   = req_ack_seq;
      new_cmd.kind      = gbns_pkg::CMD_SEND;
      push              = req_valid && req_ready;
      unique case (req_operation)
         gbns_pkg::OP_SEND: new_cmd.kind = gbns_pkg::CMD_SEND;
         gbns_pkg::OP_ACK:  new_cmd.kind = gbns_pkg::CMD_ACK;
         gbns_pkg::OP_TICK: new_cmd.kind = gbns_pkg::CMD_TICK;
         default:           push = 1'b0;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/gbns_back.sv =====
// Back end: window state, ack search, retransmit walk and result register.
`default_nettype none
module gbns_back #(
   parameter int WINDOW = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   input  wire gbns_pkg::cmd_type               cmd,
   output logic                                 cmd_pop,
   input  wire logic [gbns_pkg::TICK_W-1:0]     timeout_ticks,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [gbns_pkg::KIND_W-1:0]          rsp_kind,
   output logic [gbns_pkg::ID_W-1:0]            rsp_out_packet_id,
   output logic [gbns_pkg::SMALL_W-1:0]         rsp_out_seq,
   output logic [gbns_pkg::SMALL_W-1:0]         rsp_freed_count,
   output logic [gbns_pkg::SMALL_W-1:0]         rsp_outstanding,
   output logic                                 rsp_last
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SEQ_W = CNT_W;
   localparam int CMP_W = (SEQ_W > gbns_pkg::ACK_W) ? SEQ_W : gbns_pkg::ACK_W;

   gbns_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [SEQ_W-1:0]             next_seq_ff, next_seq_in;
   logic [gbns_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [gbns_pkg::ACK_W-1:0]   ack_ff, ack_in;

   logic [gbns_pkg::ID_W-1:0]    ids_ff  [WINDOW];
   logic [SEQ_W-1:0]             seqs_ff [WINDOW];

   logic                         rsp_valid_ff;
   logic [gbns_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic [gbns_pkg::ID_W-1:0]    rsp_id_ff;
   logic [gbns_pkg::SMALL_W-1:0] rsp_seq_ff;
   logic [gbns_pkg::SMALL_W-1:0] rsp_freed_ff;
   logic [gbns_pkg::SMALL_W-1:0] rsp_outst_ff;
   logic                         rsp_last_ff;

   logic                         out_free;
   logic [IDX_W-1:0]             scan_slot;
   logic [IDX_W-1:0]             send_slot;
   logic [SEQ_W-1:0]             cur_seq;
   logic [gbns_pkg::ID_W-1:0]    cur_id;
   logic                         match;
   logic                         is_last_idx;
   logic                         full;
   logic                         expired;
   logic [CNT_W-1:0]             idx_next;

   logic                         wr_en;
   logic                         emit;
   logic [gbns_pkg::KIND_W-1:0]  emit_kind;
   logic [gbns_pkg::ID_W-1:0]    emit_id;
   logic [SEQ_W-1:0]             emit_seq;
   logic [CNT_W-1:0]             emit_freed;
   logic [CNT_W-1:0]             emit_outst;
   logic                         emit_last;

   // ring index reduction, argument stays below 2*WINDOW
   function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] s);
      logic [IDX_W:0] r;
      r = s;
      if (s >= (IDX_W+1)'(WINDOW)) begin
         r = s - (IDX_W+1)'(WINDOW);
      end
      return r[IDX_W-1:0];
   endfunction

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign scan_slot   = wrap({1'b0, head_ff} + (IDX_W+1)'(idx_ff));
   assign send_slot   = wrap({1'b0, head_ff} + (IDX_W+1)'(count_ff));
   assign cur_seq     = seqs_ff[scan_slot];
   assign cur_id      = ids_ff[scan_slot];
   assign match       = (CMP_W'(cur_seq) == CMP_W'(ack_ff));
   assign idx_next    = idx_ff + CNT_W'(1);
   assign is_last_idx = (idx_next == count_ff);
   assign full        = (count_ff == CNT_W'(WINDOW));
   assign expired     = !(tick_ff < timeout_ticks);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbns_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               unique case (cmd.kind)
                  gbns_pkg::CMD_ACK: begin
                     if (count_ff != '0) state_in = gbns_pkg::ST_SCAN;
                  end
                  gbns_pkg::CMD_TICK: begin
                     if (expired && count_ff != '0) state_in = gbns_pkg::ST_RESEND;
                  end
                  default: state_in = gbns_pkg::ST_IDLE;
               endcase
            end
         end
         gbns_pkg::ST_SCAN: begin
            if (out_free && (match || is_last_idx)) state_in = gbns_pkg::ST_IDLE;
         end
         gbns_pkg::ST_RESEND: begin
            if (out_free && is_last_idx) state_in = gbns_pkg::ST_IDLE;
         end
         default: state_in = gbns_pkg::ST_IDLE;
      endcase
   end

   // datapath and result generation
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      next_seq_in = next_seq_ff;
      tick_in     = tick_ff;
      idx_in      = idx_ff;
      ack_in      = ack_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      emit        = 1'b0;
      emit_kind   = gbns_pkg::KIND_SENT;
      emit_id     = '0;
      emit_seq    = '0;
      emit_freed  = '0;
      emit_outst  = count_ff;
      emit_last   = 1'b1;
      unique case (state_ff)
         gbns_pkg::ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               idx_in  = '0;
               ack_in  = cmd.ack_seq;
               unique case (cmd.kind)
                  gbns_pkg::CMD_SEND: begin
                     emit = 1'b1;
                     if (full) begin
                        emit_kind = gbns_pkg::KIND_REFUSED;
                     end else begin
                        wr_en       = 1'b1;
                        emit_kind   = gbns_pkg::KIND_SENT;
                        emit_id     = cmd.packet_id;
                        emit_seq    = next_seq_ff;
                        count_in    = count_ff + CNT_W'(1);
                        emit_outst  = count_ff + CNT_W'(1);
                        next_seq_in = (next_seq_ff == SEQ_W'(WINDOW)) ? '0
                                                                      : next_seq_ff + SEQ_W'(1);
                     end
                  end
                  gbns_pkg::CMD_ACK: begin
                     // empty window: nothing to search
                     if (count_ff == '0) begin
                        emit      = 1'b1;
                        emit_kind = gbns_pkg::KIND_ACK;
                     end
                  end
                  gbns_pkg::CMD_TICK: begin
                     if (!expired) begin
                        tick_in   = tick_ff + gbns_pkg::TICK_W'(1);
                        emit      = 1'b1;
                        emit_kind = gbns_pkg::KIND_TICK;
                     end else begin
                        tick_in = '0;
                        if (count_ff == '0) begin
                           emit      = 1'b1;
                           emit_kind = gbns_pkg::KIND_EMPTY;
                        end
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         gbns_pkg::ST_SCAN: begin
            if (out_free) begin
               if (match) begin
                  emit       = 1'b1;
                  emit_kind  = gbns_pkg::KIND_ACK;
                  emit_freed = idx_next;
                  emit_outst = count_ff - idx_next;
                  head_in    = wrap({1'b0, scan_slot} + (IDX_W+1)'(1));
                  count_in   = count_ff - idx_next;
                  tick_in    = '0;
               end else if (is_last_idx) begin
                  emit      = 1'b1;
                  emit_kind = gbns_pkg::KIND_ACK;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         gbns_pkg::ST_RESEND: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = gbns_pkg::KIND_RESEND;
               emit_id   = cur_id;
               emit_seq  = cur_seq;
               emit_last = is_last_idx;
               idx_in    = idx_next;
            end
         end
         default: cmd_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbns_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         next_seq_ff  <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         next_seq_ff <= next_seq_in;
         tick_ff     <= tick_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      ack_ff <= ack_in;
      if (wr_en) begin
         ids_ff[send_slot]  <= cmd.packet_id;
         seqs_ff[send_slot] <= next_seq_ff;
      end
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_id_ff    <= emit_id;
         rsp_seq_ff   <= gbns_pkg::SMALL_W'(emit_seq);
         rsp_freed_ff <= gbns_pkg::SMALL_W'(emit_freed);
         rsp_outst_ff <= gbns_pkg::SMALL_W'(emit_outst);
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_packet_id = rsp_id_ff;
   assign rsp_out_seq       = rsp_seq_ff;
   assign rsp_freed_count   = rsp_freed_ff;
   assign rsp_outstanding   = rsp_outst_ff;
   assign rsp_last          = rsp_last_ff;

endmodule
`default_nettype wire

// ===== tb/go_back_n_sender_window_unit_test.sv =====
// Self-checking testbench for the go-back-n sender window unit.
`timescale 1ns / 100ps
module go_back_n_sender_window_unit_test;

   localparam int WIN          = 4;   // window depth, matches the DUT default
   localparam int SETTLE_TICKS = 24;  // queue depth plus worst ack scan, with margin
   localparam int IDLE_PCT     = 36;  // percent of cycles each side sits idle

   // one expected response transfer
   typedef struct packed {
      logic [gbns_pkg::KIND_W-1:0]  kind;
      logic [gbns_pkg::ID_W-1:0]    packet_id;
      logic [gbns_pkg::SMALL_W-1:0] seq;
      logic [gbns_pkg::SMALL_W-1:0] freed;
      logic [gbns_pkg::SMALL_W-1:0] outstanding;
      logic                         last;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid     = 1'b0;
   logic                            req_ready;
   logic [gbns_pkg::OP_W-1:0]       req_operation = gbns_pkg::OP_SEND;
   logic [gbns_pkg::ID_W-1:0]       req_packet_id = '0;
   logic [gbns_pkg::ACK_W-1:0]      req_ack_seq   = '0;

   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [gbns_pkg::KIND_W-1:0]     rsp_kind;
   logic [gbns_pkg::ID_W-1:0]       rsp_out_packet_id;
   logic [gbns_pkg::SMALL_W-1:0]    rsp_out_seq;
   logic [gbns_pkg::SMALL_W-1:0]    rsp_freed_count;
   logic [gbns_pkg::SMALL_W-1:0]    rsp_outstanding;
   logic                            rsp_last;

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [gbns_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [gbns_pkg::CSR_W-1:0]      csr_pwdata  = '0;
   logic [gbns_pkg::CSR_W-1:0]      csr_prdata;
   logic                            csr_pready;

   // Shadow copy of the window, kept in step with every accepted transfer
   logic [gbns_pkg::ID_W-1:0]    win_ids  [WIN];
   logic [gbns_pkg::SMALL_W-1:0] win_seqs [WIN];
   int                 win_head     = 0;
   int                 win_count    = 0;
   int                 seq_next     = 0;
   int                 ticks_seen   = 0;
   int                 timeout_limit = int'(gbns_pkg::TIMEOUT_RESET);

   window_result_type expected_results[$];
   int                error_count = 0;
   bit                steady      = 1'b0;  // set: neither side idles

   go_back_n_sender_window_unit #(.WINDOW(WIN)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_packet_id     (req_packet_id),
      .req_ack_seq       (req_ack_seq),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_packet_id (rsp_out_packet_id),
      .rsp_out_seq       (rsp_out_seq),
      .rsp_freed_count   (rsp_freed_count),
      .rsp_outstanding   (rsp_outstanding),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("go_back_n_sender_window_unit_test failed");
      $finish;
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   function automatic logic [gbns_pkg::ACK_W-1:0] rand_ack();
      return gbns_pkg::ACK_W'($urandom_range(0, 7));
   endfunction

   function automatic void queue_result(logic [gbns_pkg::KIND_W-1:0] kind,
                                        logic [gbns_pkg::ID_W-1:0] id,
                                        int seq, int freed, bit last);
      window_result_type r;
      r.kind        = kind;
      r.packet_id   = id;
      r.seq         = seq[gbns_pkg::SMALL_W-1:0];
      r.freed       = freed[gbns_pkg::SMALL_W-1:0];
      r.outstanding = win_count[gbns_pkg::SMALL_W-1:0];
      r.last        = last;
      expected_results.push_back(r);
   endfunction

   // Advance the shadow window by one accepted command and queue its responses
   function automatic void predict_window_results(logic [gbns_pkg::OP_W-1:0] op,
                                                  logic [gbns_pkg::ID_W-1:0] id,
                                                  logic [gbns_pkg::ACK_W-1:0] ack);
      int slot;
      int seq;
      int freed;
      case (op)
         gbns_pkg::OP_SEND: begin
            if (win_count >= WIN) begin
               queue_result(gbns_pkg::KIND_REFUSED, '0, 0, 0, 1'b1);
            end else begin
               slot = (win_head + win_count) % WIN;
               seq = seq_next;
               win_ids[slot]  = id;
               win_seqs[slot] = seq[gbns_pkg::SMALL_W-1:0];
               seq_next = (seq_next + 1) % (WIN + 1);
               win_count++;
               queue_result(gbns_pkg::KIND_SENT, id, seq, 0, 1'b1);
            end
         end
         gbns_pkg::OP_ACK: begin
            freed = 0;
            for (int i = 0; i < win_count; i++) begin
               if (freed == 0 && win_seqs[(win_head + i) % WIN] == ack)
                  freed = i + 1;
            end
            if (freed != 0) begin
               win_head   = (win_head + freed) % WIN;
               win_count -= freed;
               ticks_seen = 0;
            end
            queue_result(gbns_pkg::KIND_ACK, '0, 0, freed, 1'b1);
         end
         gbns_pkg::OP_TICK: begin
            if (ticks_seen < timeout_limit) begin
               ticks_seen++;
               queue_result(gbns_pkg::KIND_TICK, '0, 0, 0, 1'b1);
            end else begin
               ticks_seen = 0;
               if (win_count == 0) begin
                  queue_result(gbns_pkg::KIND_EMPTY, '0, 0, 0, 1'b1);
               end else begin
                  // go back N: replay the whole window, oldest first
                  for (int i = 0; i < win_count; i++) begin
                     slot = (win_head + i) % WIN;
                     queue_result(gbns_pkg::KIND_RESEND, win_ids[slot],
                                  int'(win_seqs[slot]), 0, i == win_count - 1);
                  end
               end
            end
         end
         default: ; // unused opcode: swallowed, nothing comes back
      endcase
   endfunction

   // One command transfer on the req channel; returns at the accepting edge
   task automatic push_request(logic [gbns_pkg::OP_W-1:0] op, logic [gbns_pkg::ID_W-1:0] id,
                               logic [gbns_pkg::ACK_W-1:0] ack);
      @(negedge clock);
      while (take_break()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_packet_id = id;
      req_ack_seq   = ack;
      do @(posedge clock); while (!req_ready);
      predict_window_results(op, id, ack);
   endtask

   // Stop sending, wait for every outstanding response, then let the pipe drain
   task automatic wait_until_settled();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // APB write of timeout_ticks followed by a read-back; only called while settled
   task automatic write_timeout(logic [gbns_pkg::TICK_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = gbns_pkg::REG_TIMEOUT;
      // upper bits are don't-care
      csr_pwdata  = {(gbns_pkg::CSR_W - gbns_pkg::TICK_W)'($urandom_range(0, 32'h00FF_FFFF)),
                     value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      timeout_limit = int'(value);
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[gbns_pkg::TICK_W-1:0] !== value) begin
         $display("%0t timeout_ticks readback expected %0d actual %0d",
                  $time, value, csr_prdata[gbns_pkg::TICK_W-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Response side back-pressure
   always @(negedge clock) begin
      rsp_ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic check_field(string name, logic [gbns_pkg::ID_W-1:0] exp_val,
                              logic [gbns_pkg::ID_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t rsp_%s expected %0h actual %0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Response checker: every transfer must match the oldest expectation
   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected response expected none actual kind %0d",
                     $time, rsp_kind);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", gbns_pkg::ID_W'(want.kind), gbns_pkg::ID_W'(rsp_kind));
            check_field("out_packet_id", want.packet_id, rsp_out_packet_id);
            check_field("out_seq", gbns_pkg::ID_W'(want.seq), gbns_pkg::ID_W'(rsp_out_seq));
            check_field("freed_count", gbns_pkg::ID_W'(want.freed),
                        gbns_pkg::ID_W'(rsp_freed_count));
            check_field("outstanding", gbns_pkg::ID_W'(want.outstanding),
                        gbns_pkg::ID_W'(rsp_outstanding));
            check_field("last", gbns_pkg::ID_W'(want.last), gbns_pkg::ID_W'(rsp_last));
         end
      end
   end

   // Reset value of timeout_ticks: three plain ticks, then a timeout on an empty window
   task automatic test_reset_timeout();
      repeat (4) push_request(gbns_pkg::OP_TICK, $urandom, rand_ack());
   endtask

   // Fill the window with extreme ids, then one send too many
   task automatic test_window_full();
      push_request(gbns_pkg::OP_SEND, 32'h0000_0000, 3'd0);
      push_request(gbns_pkg::OP_SEND, 32'hFFFF_FFFF, 3'd7);
      push_request(gbns_pkg::OP_SEND, 32'hA5A5_A5A5, 3'd2);
      push_request(gbns_pkg::OP_SEND, 32'h5A5A_5A5A, 3'd5);
      push_request(gbns_pkg::OP_SEND, 32'h8000_0001, 3'd1);
   endtask

   // Acks that match nothing leave the tick count alone; opcode 3 is dropped
   task automatic test_ack_miss_and_unused_opcode();
      push_request(gbns_pkg::OP_ACK,  $urandom, 3'd7);
      push_request(gbns_pkg::OP_ACK,  $urandom, 3'd4);
      push_request(gbns_pkg::OP_NONE, $urandom, rand_ack());
      push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
   endtask

   // Timeout with a full window: four resends, last flagged on the fourth
   task automatic test_resend_burst();
      repeat (3) push_request(gbns_pkg::OP_TICK, $urandom, rand_ack());
   endtask

   // Cumulative ack, sequence wrap past WINDOW, then an ack that empties the window
   task automatic test_ack_release_and_wrap();
      push_request(gbns_pkg::OP_ACK,  $urandom, 3'd1);
      push_request(gbns_pkg::OP_SEND, $urandom, 3'd0);
      push_request(gbns_pkg::OP_SEND, $urandom, 3'd0);
      push_request(gbns_pkg::OP_ACK,  $urandom, 3'd0);
      push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
   endtask

   // Register extremes: zero times out on every tick, 255 practically never; then a limit of 1
   task automatic test_timeout_register();
      wait_until_settled();
      write_timeout(8'd0);
      push_request(gbns_pkg::OP_SEND, $urandom, 3'd0);
      push_request(gbns_pkg::OP_SEND, $urandom, 3'd0);
      push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
      push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
      wait_until_settled();
      write_timeout(8'd255);
      repeat (4) push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
      wait_until_settled();
      write_timeout(8'd1);
      repeat (3) push_request(gbns_pkg::OP_TICK, $urandom, 3'd0);
   endtask

   // Mostly protocol-shaped traffic: acks aim at outstanding sequence numbers
   task automatic run_random_phase(int items);
      int done;
      int pick;
      logic [gbns_pkg::OP_W-1:0]  op;
      logic [gbns_pkg::ACK_W-1:0] ack;
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         ack  = rand_ack();
         if (pick < 40) begin
            op = gbns_pkg::OP_SEND;
         end else if (pick < 70) begin
            op = gbns_pkg::OP_ACK;
            if (win_count > 0 && $urandom_range(0, 99) < 80)
               ack = win_seqs[(win_head + $urandom_range(0, win_count - 1)) % WIN];
         end else if (pick < 95) begin
            op = gbns_pkg::OP_TICK;
         end else begin
            op = gbns_pkg::OP_NONE;
         end
         push_request(op, $urandom, ack);
         if (op != gbns_pkg::OP_NONE) done++;
      end
   endtask

   task automatic test_random_traffic();
      wait_until_settled();
      write_timeout(8'd2);
      run_random_phase(50);
      wait_until_settled();
      write_timeout(8'd0);
      run_random_phase(40);
      // full-rate stretch on both channels
      steady = 1'b1;
      run_random_phase(50);
      steady = 1'b0;
      wait_until_settled();
      write_timeout(8'd255);
      run_random_phase(30);
      wait_until_settled();
      write_timeout(gbns_pkg::TICK_W'($urandom_range(1, 6)));
      run_random_phase(40);
      // hold the sender off until every response is back, then resume mid-phase
      wait_until_settled();
      run_random_phase(40);
      wait_until_settled();
      write_timeout(gbns_pkg::TIMEOUT_RESET);
      run_random_phase(50);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_timeout();
      test_window_full();
      test_ack_miss_and_unused_opcode();
      test_resend_burst();
      test_ack_release_and_wrap();
      test_timeout_register();
      test_random_traffic();

      // drain, then give the block time to emit anything stray
      wait_until_settled();
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("go_back_n_sender_window_unit_test passed");
      end else begin
         $display("go_back_n_sender_window_unit_test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/gbns_pkg.sv
sv/gbns_front.sv
sv/gbns_back.sv
sv/go_back_n_sender_window_unit.sv
tb/go_back_n_sender_window_unit_test.sv
